FILE: rtl/euler_to_quaternion_unit_assert.svh
// assertion macros used by the top-level rtl
`ifndef EULER_TO_QUATERNION_UNIT_ASSERT_SVH
`define EULER_TO_QUATERNION_UNIT_ASSERT_SVH

// condition in this cycle implies condition in this cycle, outside reset
`define E2Q_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// condition implies condition in the next cycle, checked during reset too
`define E2Q_ASSERT_NEXT(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("assertion failed");

`endif

FILE: rtl/e2q_pkg.sv
package e2q_pkg;
    localparam int ANGLE_W = 16;
    localparam int COMP_W = 16;
    localparam int X_W = 34;
    localparam int Z_W = 33;
    localparam int SC_W = 32;
    localparam int STEPS = 30;
    localparam int STEPS_PER_STAGE = 3;
    localparam int CORDIC_STAGES = STEPS / STEPS_PER_STAGE;
    // reduce, scale, iterations, quadrant map
    localparam int CORDIC_LAT = CORDIC_STAGES + 3;
    localparam int COMBINE_LAT = 5;
    localparam int LAT = CORDIC_LAT + COMBINE_LAT;

    localparam logic [16:0] TURN_UNITS = 17'd46080;
    localparam logic [15:0] QUAD1 = 16'd11520;
    localparam logic [15:0] QUAD2 = 16'd23040;
    localparam logic [15:0] QUAD3 = 16'd34560;
    localparam logic [33:0] RAD_SCALE = 34'd9595049034;
    localparam logic signed [X_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [31:0] ATAN [0:STEPS-1] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687, 32'sd33543516, 32'sd16775851, 32'sd8388437,
        32'sd4194283, 32'sd2097149, 32'sd1048576, 32'sd524288, 32'sd262144,
        32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
        32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128,
        32'sd64, 32'sd32, 32'sd16, 32'sd8, 32'sd4, 32'sd2
    };

    typedef enum logic [1:0] {
        t_QUAD0 = 2'd0,
        t_QUAD1 = 2'd1,
        t_QUAD2 = 2'd2,
        t_QUAD3 = 2'd3
    } t_quad;

    // q2.30 product rounded to q4.30, floor after half lsb
    function automatic logic signed [33:0] round30(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< 29);
        return t[63:30];
    endfunction
endpackage

FILE: rtl/e2q_cordic.sv
module e2q_cordic (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] i_angle,
    output logic signed [e2q_pkg::SC_W-1:0]    o_cos,
    output logic signed [e2q_pkg::SC_W-1:0]    o_sin
);
    import e2q_pkg::*;

    logic [15:0] n_a;
    t_quad       n_q;
    logic [15:0] n_r;
    t_quad       r_q0;
    logic [13:0] r_r0;
    t_quad       r_q1;
    logic [47:0] r_prod;

    // one turn of half angle, input never exceeds one turn in magnitude
    always_comb begin
        logic [16:0] s;
        s = {i_angle[ANGLE_W-1], i_angle};
        if (i_angle[ANGLE_W-1]) begin
            s = s + TURN_UNITS;
        end
        n_a = s[15:0];
        if (n_a >= QUAD3) begin
            n_q = t_QUAD3;
            n_r = n_a - QUAD3;
        end else if (n_a >= QUAD2) begin
            n_q = t_QUAD2;
            n_r = n_a - QUAD2;
        end else if (n_a >= QUAD1) begin
            n_q = t_QUAD1;
            n_r = n_a - QUAD1;
        end else begin
            n_q = t_QUAD0;
            n_r = n_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0   <= n_q;
            r_r0   <= n_r[13:0];
            r_q1   <= r_q0;
            r_prod <= 48'(r_r0 * RAD_SCALE);
        end
    end

    logic signed [X_W-1:0] r_x [0:CORDIC_STAGES];
    logic signed [X_W-1:0] r_y [0:CORDIC_STAGES];
    logic signed [Z_W-1:0] r_z [0:CORDIC_STAGES];
    t_quad                 r_q [0:CORDIC_STAGES];

    always_comb begin
        r_x[0] = CORDIC_GAIN;
        r_y[0] = '0;
        r_z[0] = $signed({1'b0, r_prod[47:16]});
        r_q[0] = r_q1;
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        logic signed [X_W-1:0] n_x;
        logic signed [X_W-1:0] n_y;
        logic signed [Z_W-1:0] n_z;
        always_comb begin
            logic signed [X_W-1:0] nx;
            n_x = r_x[k];
            n_y = r_y[k];
            n_z = r_z[k];
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                if (n_z >= 0) begin
                    nx  = n_x - (n_y >>> (k * STEPS_PER_STAGE + j));
                    n_y = n_y + (n_x >>> (k * STEPS_PER_STAGE + j));
                    n_z = n_z - Z_W'(ATAN[k * STEPS_PER_STAGE + j]);
                end else begin
                    nx  = n_x + (n_y >>> (k * STEPS_PER_STAGE + j));
                    n_y = n_y - (n_x >>> (k * STEPS_PER_STAGE + j));
                    n_z = n_z + Z_W'(ATAN[k * STEPS_PER_STAGE + j]);
                end
                n_x = nx;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1] <= n_x;
                r_y[k+1] <= n_y;
                r_z[k+1] <= n_z;
                r_q[k+1] <= r_q[k];
            end
        end
    end

    logic signed [X_W-1:0] n_c;
    logic signed [X_W-1:0] n_s;
    logic signed [SC_W-1:0] r_cos;
    logic signed [SC_W-1:0] r_sin;

    always_comb begin
        case (r_q[CORDIC_STAGES])
            t_QUAD0: begin
                n_c = r_x[CORDIC_STAGES];
                n_s = r_y[CORDIC_STAGES];
            end
            t_QUAD1: begin
                n_c = -r_y[CORDIC_STAGES];
                n_s = r_x[CORDIC_STAGES];
            end
            t_QUAD2: begin
                n_c = -r_x[CORDIC_STAGES];
                n_s = -r_y[CORDIC_STAGES];
            end
            default: begin
                n_c = r_y[CORDIC_STAGES];
                n_s = -r_x[CORDIC_STAGES];
            end
        endcase
    end

    // magnitudes stay near one, well inside 32 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_c[SC_W-1:0];
            r_sin <= n_s[SC_W-1:0];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule

FILE: rtl/e2q_combine.sv
module e2q_combine (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [e2q_pkg::SC_W-1:0] i_cp,
    input  logic signed [e2q_pkg::SC_W-1:0] i_sp,
    input  logic signed [e2q_pkg::SC_W-1:0] i_cy,
    input  logic signed [e2q_pkg::SC_W-1:0] i_sy,
    input  logic signed [e2q_pkg::SC_W-1:0] i_cr,
    input  logic signed [e2q_pkg::SC_W-1:0] i_sr,
    output logic signed [e2q_pkg::COMP_W-1:0] o_w,
    output logic signed [e2q_pkg::COMP_W-1:0] o_x,
    output logic signed [e2q_pkg::COMP_W-1:0] o_y,
    output logic signed [e2q_pkg::COMP_W-1:0] o_z
);
    import e2q_pkg::*;

    localparam int SHIFT = 30 - (COMP_W - 2);

    logic signed [63:0] r_pcc, r_pss, r_psc, r_pcs;
    logic signed [SC_W-1:0] r_cy1, r_sy1, r_cy2, r_sy2;
    logic signed [SC_W-1:0] r_rcc, r_rss, r_rsc, r_rcs;
    logic signed [63:0] r_t [0:7];
    logic signed [33:0] r_u [0:7];
    logic signed [COMP_W-1:0] r_w, r_x, r_y, r_z;

    function automatic logic signed [COMP_W-1:0] to_comp(input logic signed [34:0] v);
        logic signed [34:0] t;
        logic signed [34:0] hi;
        logic signed [34:0] lo;
        hi = (35'sd1 <<< (COMP_W - 1)) - 35'sd1;
        lo = -hi - 35'sd1;
        t = (v + (35'sd1 <<< (SHIFT - 1))) >>> SHIFT;
        if (t > hi) begin
            t = hi;
        end
        if (t < lo) begin
            t = lo;
        end
        return t[COMP_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pcc <= i_cr * i_cp;
            r_pss <= i_sr * i_sp;
            r_psc <= i_sr * i_cp;
            r_pcs <= i_cr * i_sp;
            r_cy1 <= i_cy;
            r_sy1 <= i_sy;

            r_rcc <= SC_W'(round30(r_pcc));
            r_rss <= SC_W'(round30(r_pss));
            r_rsc <= SC_W'(round30(r_psc));
            r_rcs <= SC_W'(round30(r_pcs));
            r_cy2 <= r_cy1;
            r_sy2 <= r_sy1;

            r_t[0] <= r_rcc * r_cy2;
            r_t[1] <= r_rss * r_sy2;
            r_t[2] <= r_rsc * r_cy2;
            r_t[3] <= r_rcs * r_sy2;
            r_t[4] <= r_rcs * r_cy2;
            r_t[5] <= r_rsc * r_sy2;
            r_t[6] <= r_rcc * r_sy2;
            r_t[7] <= r_rss * r_cy2;

            for (int i = 0; i < 8; i++) begin
                r_u[i] <= round30(r_t[i]);
            end

            r_w <= to_comp(35'(r_u[0]) + 35'(r_u[1]));
            r_x <= to_comp(35'(r_u[2]) - 35'(r_u[3]));
            r_y <= to_comp(35'(r_u[4]) + 35'(r_u[5]));
            r_z <= to_comp(35'(r_u[6]) - 35'(r_u[7]));
        end
    end

    assign o_w = r_w;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

FILE: rtl/euler_to_quaternion_unit.sv
// throughput: one word per cycle when not stalled, set by the fully
// pipelined cordic lanes and multiplier chain; a stall on the output
// freezes the whole pipeline
// reset: synchronous active low, clears the valid bits only
module euler_to_quaternion_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  i_angle_x,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  i_angle_y,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  i_angle_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [e2q_pkg::COMP_W-1:0]   o_quat_w,
    output logic signed [e2q_pkg::COMP_W-1:0]   o_quat_x,
    output logic signed [e2q_pkg::COMP_W-1:0]   o_quat_y,
    output logic signed [e2q_pkg::COMP_W-1:0]   o_quat_z
);
    import e2q_pkg::*;
    `include "euler_to_quaternion_unit_assert.svh"

    logic [LAT-1:0] r_valid;
    logic           adv;
    logic signed [SC_W-1:0] cp, sp, cy, sy, cr, sr;

    assign adv     = !r_valid[LAT-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_valid[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (adv) begin
            r_valid <= {r_valid[LAT-2:0], i_valid};
        end
    end

    e2q_cordic u_pitch (
        .i_clk(i_clk), .i_en(adv), .i_angle(i_angle_x), .o_cos(cp), .o_sin(sp)
    );
    e2q_cordic u_yaw (
        .i_clk(i_clk), .i_en(adv), .i_angle(i_angle_y), .o_cos(cy), .o_sin(sy)
    );
    e2q_cordic u_roll (
        .i_clk(i_clk), .i_en(adv), .i_angle(i_angle_z), .o_cos(cr), .o_sin(sr)
    );

    e2q_combine u_combine (
        .i_clk(i_clk), .i_en(adv),
        .i_cp(cp), .i_sp(sp), .i_cy(cy), .i_sy(sy), .i_cr(cr), .i_sr(sr),
        .o_w(o_quat_w), .o_x(o_quat_x), .o_y(o_quat_y), .o_z(o_quat_z)
    );

    `E2Q_ASSERT_NEXT(a_reset_clears, i_clk, !i_rst_n, !o_valid)
    `E2Q_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n && i_valid && o_ready, r_valid[0])
    `E2Q_ASSERT_IMP(a_w_unit, i_clk, i_rst_n, o_valid,
        o_quat_w <= 16'sd16500 && o_quat_w >= -16'sd16500)
    `E2Q_ASSERT_IMP(a_x_unit, i_clk, i_rst_n, o_valid,
        o_quat_x <= 16'sd16500 && o_quat_x >= -16'sd16500)
endmodule
